// ===== hw/rtl/dptr_pkg.sv =====
// Shared types and constants for the dual-plane tilemap renderer.
package dptr_pkg;

  // Tilemap geometry.
  localparam int COLS_PER_BLOCK = 64;
  localparam int HALF_BYTES     = 2048;
  localparam int IDX_W          = $clog2(HALF_BYTES);

  // Each video RAM half (tile-code bytes, attribute bytes) spans all four blocks.
  localparam int RAM_DEPTH = 4 * HALF_BYTES;
  localparam int RAM_AW    = $clog2(RAM_DEPTH);

  localparam logic [15:0] CLEAR_WORD = 16'hffff;

  typedef enum logic [1:0] {
    REQ_WRITE   = 2'd0,
    REQ_READ    = 2'd1,
    REQ_ADDR    = 2'd2,
    REQ_COMPOSE = 2'd3
  } req_e;

  // Port controls for the two video RAM halves.
  typedef struct packed {
    logic              we_lo;
    logic              we_hi;
    logic              re;
    logic [RAM_AW-1:0] waddr;
    logic [7:0]        wdata;
    logic [RAM_AW-1:0] raddr_a;
    logic [RAM_AW-1:0] raddr_b;
  } ram_req_t;

  // Item held while its video RAM reads complete.
  typedef struct packed {
    req_e        req;
    logic        sel_hi;
    logic [5:0]  sub;
    logic [15:0] bg_word;
    logic [15:0] fg_word;
  } stg_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [20:0] bg_rom_addr;
    logic [20:0] fg_rom_addr;
    logic [14:0] pixel_color;
  } res_t;

endpackage

// ===== hw/rtl/dptr_ram.sv =====
// Generic single-write, dual-read synchronous RAM with registered read data.
module dptr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ===== hw/rtl/dptr_addr.sv =====
// Video RAM port control: byte access addressing and pixel-to-tile index lookup.
module dptr_addr
  import dptr_pkg::*;
(
  input  logic        accept_i,
  input  req_e        req_i,
  input  logic [13:0] vram_offset_i,
  input  logic [7:0]  write_data_i,
  input  logic [9:0]  pixel_x_i,
  input  logic [7:0]  pixel_y_i,
  output ram_req_t    ram_o
);

  localparam logic [10:0] HalfPx = 11'(COLS_PER_BLOCK * 8);
  localparam logic [IDX_W-1:0] ColsW = IDX_W'(COLS_PER_BLOCK);

  logic             second;
  logic [IDX_W-1:0] col;
  logic [IDX_W-1:0] row_base;
  logic [IDX_W-1:0] idx;
  logic [RAM_AW-1:0] byte_addr;

  always_comb begin
    second   = {1'b0, pixel_x_i} >= HalfPx;
    col      = IDX_W'(pixel_x_i[9:3]) - (second ? ColsW : '0);
    // Row and column wrap within the 2048-entry half of a block.
    row_base = IDX_W'(pixel_y_i[7:3]) * ColsW;
    idx      = row_base + col;
    byte_addr = {vram_offset_i[13:12], vram_offset_i[10:0]};

    ram_o.we_lo   = accept_i && (req_i == REQ_WRITE) && !vram_offset_i[11];
    ram_o.we_hi   = accept_i && (req_i == REQ_WRITE) && vram_offset_i[11];
    ram_o.re      = accept_i && ((req_i == REQ_READ) || (req_i == REQ_ADDR));
    ram_o.waddr   = byte_addr;
    ram_o.wdata   = write_data_i;
    if (req_i == REQ_READ) begin
      ram_o.raddr_a = byte_addr;
    end else begin
      ram_o.raddr_a = {second, 1'b0, idx};
    end
    ram_o.raddr_b = {second, 1'b1, idx};
  end

endmodule

// ===== hw/rtl/dptr_fmt.sv =====
// Result formatting: byte reads, tile ROM addresses and pixel composition.
module dptr_fmt
  import dptr_pkg::*;
(
  input  stg_t       stg_i,
  input  logic [7:0] lo_a_i,
  input  logic [7:0] lo_b_i,
  input  logic [7:0] hi_a_i,
  input  logic [7:0] hi_b_i,
  output res_t       res_o
);

  function automatic logic [15:0] unscramble(input logic [15:0] w);
    return {w[15:13], w[2:0], w[7:3], w[12:8]};
  endfunction

  logic [15:0] bg_w;
  logic [15:0] fg_w;
  logic [15:0] pick;

  always_comb begin
    bg_w = unscramble(stg_i.bg_word);
    fg_w = unscramble(stg_i.fg_word);
    if (fg_w != CLEAR_WORD && fg_w != 16'h0000) begin
      pick = fg_w;
    end else if (bg_w != CLEAR_WORD) begin
      pick = bg_w;
    end else begin
      pick = 16'h0000;
    end

    res_o = '0;
    case (stg_i.req)
      REQ_READ: begin
        res_o.read_data = stg_i.sel_hi ? hi_a_i : lo_a_i;
      end
      REQ_ADDR: begin
        // Overlay codes sit in the upper bank, which sets the top address bit.
        res_o.bg_rom_addr = {1'b0, hi_a_i[5:0], lo_a_i, stg_i.sub};
        res_o.fg_rom_addr = {1'b1, hi_b_i[5:0], lo_b_i, stg_i.sub};
      end
      REQ_COMPOSE: begin
        res_o.pixel_color = pick[14:0];
      end
      default: begin
        res_o = '0;
      end
    endcase
  end

endmodule

// ===== hw/rtl/dual_plane_tilemap_renderer_core.sv =====
// Top level of the dual-plane tilemap renderer: handshake, pipeline and video RAM.
//
//   channel    direction  tuser         tdata
//   s_axis     in         req_type      offset, write byte, pixel x/y, two ROM words
//   m_axis     out        -             read byte, two ROM addresses, color
//
// One item is taken per cycle while m_axis is not stalled. A result is offered on m_axis
// from the result register: the video RAM read and the stage register load when the item
// transfers, and the result register loads from them once the output can take a result.
// Video RAM contents are undefined after reset; there is no clearing pass.
// A stalled output holds one result and one item in flight, then s_axis stalls.
// A write commits before the next item's reads issue, so no forwarding is needed.
module dual_plane_tilemap_renderer_core
  import dptr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [1:0]  s_axis_tuser_i,   // req_type
  // vram_offset[13:0], write_data[21:14], pixel_x[31:22], pixel_y[39:32],
  // bg_pixel_word[55:40], fg_pixel_word[71:56]
  input  logic [71:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // read_data[7:0], bg_rom_addr[28:8], fg_rom_addr[49:29], pixel_color[64:50],
  // zero[71:65]
  output logic [71:0] m_axis_tdata_o
);

  logic     accept;
  logic     advance;
  req_e     req;
  ram_req_t ram;
  logic     stg_v_q, stg_v_d;
  stg_t     stg_q;
  logic     out_v_q, out_v_d;
  res_t     out_q;
  res_t     res;
  logic [7:0] lo_a, lo_b, hi_a, hi_b;

  assign req     = req_e'(s_axis_tuser_i);
  assign advance = stg_v_q && (!out_v_q || m_axis_tready_i);
  assign s_axis_tready_o = !stg_v_q || advance;
  assign accept  = s_axis_tvalid_i && s_axis_tready_o;

  dptr_addr u_addr (
    .accept_i      (accept),
    .req_i         (req),
    .vram_offset_i (s_axis_tdata_i[13:0]),
    .write_data_i  (s_axis_tdata_i[21:14]),
    .pixel_x_i     (s_axis_tdata_i[31:22]),
    .pixel_y_i     (s_axis_tdata_i[39:32]),
    .ram_o         (ram)
  );

  dptr_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_ram_lo (
    .clk_i     (clk_i),
    .we_i      (ram.we_lo),
    .waddr_i   (ram.waddr),
    .wdata_i   (ram.wdata),
    .re_i      (ram.re),
    .raddr_a_i (ram.raddr_a),
    .raddr_b_i (ram.raddr_b),
    .rdata_a_o (lo_a),
    .rdata_b_o (lo_b)
  );

  dptr_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_ram_hi (
    .clk_i     (clk_i),
    .we_i      (ram.we_hi),
    .waddr_i   (ram.waddr),
    .wdata_i   (ram.wdata),
    .re_i      (ram.re),
    .raddr_a_i (ram.raddr_a),
    .raddr_b_i (ram.raddr_b),
    .rdata_a_o (hi_a),
    .rdata_b_o (hi_b)
  );

  dptr_fmt u_fmt (
    .stg_i  (stg_q),
    .lo_a_i (lo_a),
    .lo_b_i (lo_b),
    .hi_a_i (hi_a),
    .hi_b_i (hi_b),
    .res_o  (res)
  );

  always_comb begin
    stg_v_d = stg_v_q;
    if (accept) begin
      stg_v_d = 1'b1;
    end else if (advance) begin
      stg_v_d = 1'b0;
    end
    out_v_d = out_v_q;
    if (advance) begin
      out_v_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      stg_v_q <= stg_v_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stg_q.req     <= req;
      stg_q.sel_hi  <= s_axis_tdata_i[11];
      stg_q.sub     <= {s_axis_tdata_i[34:32], s_axis_tdata_i[24:22]};
      stg_q.bg_word <= s_axis_tdata_i[55:40];
      stg_q.fg_word <= s_axis_tdata_i[71:56];
    end
    if (advance) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {7'd0, out_q.pixel_color, out_q.fg_rom_addr,
                            out_q.bg_rom_addr, out_q.read_data};

  // A full pipeline with a stalled output must refuse new items.
  a_stall_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stg_v_q && out_v_q && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("input accepted while pipeline is blocked");

  // A new result only comes from an item that was in flight.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(stg_v_q))
    else $error("result appeared without an item in flight");

  // Every transfer reaches the stage register on the next cycle.
  a_accept_fills_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> stg_v_q)
    else $error("accepted item lost before its RAM read");

  // Writes and reads of the video RAM never issue in the same cycle.
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram.we_lo || ram.we_hi) |-> !ram.re)
    else $error("video RAM write overlaps a read");

endmodule

// ===== verif/tb_dual_plane_tilemap_renderer_core.sv =====
// Self-checking stream testbench for the dual-plane tilemap renderer core.
`timescale 1ns / 100ps

module tb_dual_plane_tilemap_renderer_core;
  import dptr_pkg::*;

  localparam int          VRAM_BYTES   = 16384;
  localparam int          BLOCK_BYTES  = 4096;
  localparam int          HALF_X       = COLS_PER_BLOCK * 8;
  localparam logic [14:0] OVERLAY_BANK = 15'h4000;
  localparam int          NUM_ITEMS    = 1650;
  localparam int          IDLE_PCT     = 20;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          WATCHDOG_MAX = 5000;

  typedef struct packed {
    req_e        kind;
    logic [13:0] offset;
    logic [7:0]  wdata;
    logic [9:0]  px;
    logic [7:0]  py;
    logic [15:0] bg_word;
    logic [15:0] fg_word;
    bit          drain_first;
  } render_req_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [1:0]  s_axis_tuser_i;   // req_type
  // vram_offset[13:0], write_data[21:14], pixel_x[31:22], pixel_y[39:32],
  // bg_pixel_word[55:40], fg_pixel_word[71:56]
  logic [71:0] s_axis_tdata_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  // read_data[7:0], bg_rom_addr[28:8], fg_rom_addr[49:29], pixel_color[64:50],
  // zero[71:65]
  logic [71:0] m_axis_tdata_o;

  dual_plane_tilemap_renderer_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tuser_i (s_axis_tuser_i),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Stimulus bookkeeping: which video RAM bytes the generated stream has written.
  render_req_t pending_reqs[$];
  bit          vram_written[VRAM_BYTES];
  int          written_offsets[$];
  int          ready_tiles[$];

  // Predictor state, updated in transfer order.
  logic [7:0]  vram_mirror[VRAM_BYTES];
  res_t        expected_results[$];

  int          mismatches;
  int          results_seen;
  int          hold_left;
  int          stall_cycles;
  int          cycle_count;
  bit          quiet;
  render_req_t cur_req;
  bit          fire;
  bit          go;
  res_t        got;
  res_t        want;

  // No random idling on either side inside this window.
  assign quiet = (cycle_count >= 1500) && (cycle_count < 2300);

  function automatic logic [15:0] unscramble_word(input logic [15:0] w);
    return {w[15:13], w[2:0], w[7:3], w[12:8]};
  endfunction

  function automatic logic [13:0] tile_code_at(input int blk, input int idx);
    logic [7:0] lo;
    logic [7:0] hi;
    lo = vram_mirror[blk * BLOCK_BYTES + idx];
    hi = vram_mirror[blk * BLOCK_BYTES + HALF_BYTES + idx];
    return {hi[5:0], lo};
  endfunction

  task automatic predict_render_result(input render_req_t r);
    res_t        res;
    int          second;
    int          col;
    int          row;
    int          idx;
    logic [5:0]  sub;
    logic [14:0] bgc;
    logic [14:0] fgc;
    logic [15:0] b;
    logic [15:0] f;
    logic [15:0] c;
    res = '0;
    case (r.kind)
      REQ_WRITE: begin
        vram_mirror[r.offset] = r.wdata;
      end
      REQ_READ: begin
        res.read_data = vram_mirror[r.offset];
      end
      REQ_ADDR: begin
        second = (r.px >= HALF_X) ? 1 : 0;
        col    = int'(r.px >> 3) - (second ? COLS_PER_BLOCK : 0);
        row    = int'(r.py >> 3);
        idx    = (row * COLS_PER_BLOCK + col) & (HALF_BYTES - 1);
        sub    = {r.py[2:0], r.px[2:0]};
        bgc    = {1'b0, tile_code_at(second * 2, idx)};
        fgc    = {1'b0, tile_code_at(second * 2 + 1, idx)} | OVERLAY_BANK;
        res.bg_rom_addr = {bgc, sub};
        res.fg_rom_addr = {fgc, sub};
      end
      default: begin
        b = unscramble_word(r.bg_word);
        f = unscramble_word(r.fg_word);
        c = '0;
        if (f != CLEAR_WORD && f != 16'h0000) begin
          c = f;
        end else if (b != CLEAR_WORD) begin
          c = b;
        end
        res.pixel_color = c[14:0];
      end
    endcase
    expected_results.push_back(res);
  endtask

  function automatic render_req_t random_req(input req_e kind);
    render_req_t r;
    r.kind        = kind;
    r.offset      = 14'($urandom);
    r.wdata       = 8'($urandom);
    r.px          = 10'($urandom);
    r.py          = 8'($urandom);
    r.bg_word     = 16'($urandom);
    r.fg_word     = 16'($urandom);
    r.drain_first = 1'b0;
    return r;
  endfunction

  task automatic push_write(input int off, input logic [7:0] data);
    render_req_t r;
    r = random_req(REQ_WRITE);
    r.offset = 14'(off);
    r.wdata  = data;
    if (!vram_written[off]) begin
      written_offsets.push_back(off);
    end
    vram_written[off] = 1'b1;
    pending_reqs.push_back(r);
  endtask

  task automatic push_read(input int off);
    render_req_t r;
    r = random_req(REQ_READ);
    r.offset = 14'(off);
    pending_reqs.push_back(r);
  endtask

  task automatic push_lookup(input int px, input int py);
    render_req_t r;
    r = random_req(REQ_ADDR);
    r.px = 10'(px);
    r.py = 8'(py);
    pending_reqs.push_back(r);
  endtask

  task automatic push_compose(input logic [15:0] bgw, input logic [15:0] fgw);
    render_req_t r;
    r = random_req(REQ_COMPOSE);
    r.bg_word = bgw;
    r.fg_word = fgw;
    pending_reqs.push_back(r);
  endtask

  // A lookup touches the low and attribute bytes of both planes for one tile.
  task automatic push_tile_lookup(input int tile);
    int second;
    int idx;
    second = tile / HALF_BYTES;
    idx    = tile % HALF_BYTES;
    push_lookup(second * HALF_X + (idx % COLS_PER_BLOCK) * 8 + $urandom_range(7),
                (idx / COLS_PER_BLOCK) * 8 + $urandom_range(7));
  endtask

  task automatic build_stimulus();
    int          first_random;
    int          pick;
    int          second;
    int          idx;
    int          blk;
    int          n;
    logic [15:0] bgw;
    logic [15:0] fgw;
    render_req_t tmp;
    // Tile 0 in all four blocks, and the last tile of the right-hand blocks at all ones.
    push_write(0, 8'h00);
    push_write(HALF_BYTES, 8'hff);
    push_write(BLOCK_BYTES, 8'hff);
    push_write(BLOCK_BYTES + HALF_BYTES, 8'h00);
    push_write(2 * BLOCK_BYTES, 8'h5a);
    push_write(2 * BLOCK_BYTES + HALF_BYTES, 8'hc3);
    push_write(3 * BLOCK_BYTES, 8'hff);
    push_write(3 * BLOCK_BYTES + HALF_BYTES, 8'hff);
    push_write(2 * BLOCK_BYTES + HALF_BYTES - 1, 8'hff);
    push_write(3 * BLOCK_BYTES - 1, 8'hff);
    push_write(3 * BLOCK_BYTES + HALF_BYTES - 1, 8'hff);
    push_write(VRAM_BYTES - 1, 8'hff);
    push_lookup(0, 0);
    push_lookup(HALF_X + 7, 7);
    push_lookup(1023, 255);
    push_read(0);
    push_read(VRAM_BYTES - 1);
    // Overlay clear by all ones or all zeros, background clear, bit 15 dropped.
    push_compose(16'h1234, 16'hffff);
    push_compose(16'h7fff, 16'h0000);
    push_compose(16'hffff, 16'hffff);
    push_compose(16'hffff, 16'h0000);
    push_compose(16'h0000, 16'h5a5a);
    push_compose(16'h0000, 16'h8000);
    first_random = pending_reqs.size();

    while (pending_reqs.size() < NUM_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        // Fill one tile of both planes, then look pixels of it up.
        second = $urandom_range(1);
        idx    = $urandom_range(HALF_BYTES - 1);
        for (blk = second * 2; blk < second * 2 + 2; blk++) begin
          push_write(blk * BLOCK_BYTES + idx, 8'($urandom));
          push_write(blk * BLOCK_BYTES + HALF_BYTES + idx, 8'($urandom));
        end
        ready_tiles.push_back(second * HALF_BYTES + idx);
        n = $urandom_range(1, 3);
        repeat (n) push_tile_lookup(second * HALF_BYTES + idx);
      end else if (pick < 55) begin
        push_write($urandom_range(VRAM_BYTES - 1), 8'($urandom));
      end else if (pick < 70) begin
        push_read(written_offsets[$urandom_range(written_offsets.size() - 1)]);
      end else if (pick < 85) begin
        bgw = 16'($urandom);
        fgw = 16'($urandom);
        case ($urandom_range(5))
          0: fgw = 16'h0000;
          1: fgw = 16'hffff;
          2: begin
            fgw = 16'h0000;
            bgw = 16'hffff;
          end
          3: begin
            fgw = 16'hffff;
            bgw = 16'hffff;
          end
          default: ;
        endcase
        push_compose(bgw, fgw);
      end else if (ready_tiles.size() > 0) begin
        push_tile_lookup(ready_tiles[$urandom_range(ready_tiles.size() - 1)]);
      end
    end

    // The sender waits for an empty pipeline before these items.
    tmp = pending_reqs[first_random];
    tmp.drain_first = 1'b1;
    pending_reqs[first_random] = tmp;
    tmp = pending_reqs[1000];
    tmp.drain_first = 1'b1;
    pending_reqs[1000] = tmp;
  endtask

  // Sender.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tuser_i  <= REQ_WRITE;
      s_axis_tdata_i  <= '0;
    end else begin
      fire = s_axis_tvalid_i && s_axis_tready_o;
      if (fire) begin
        predict_render_result(cur_req);
      end
      if (!s_axis_tvalid_i || fire) begin
        go = (pending_reqs.size() > 0) && (quiet || $urandom_range(99) >= IDLE_PCT);
        if (go && pending_reqs[0].drain_first && expected_results.size() != 0) begin
          go = 1'b0;
        end
        if (go) begin
          cur_req = pending_reqs.pop_front();
          s_axis_tuser_i <= cur_req.kind;
          s_axis_tdata_i <= {cur_req.fg_word, cur_req.bg_word, cur_req.py, cur_req.px,
                             cur_req.wdata, cur_req.offset};
        end
        s_axis_tvalid_i <= go;
      end
    end
  end

  task automatic check_field(input string label, input logic [20:0] exp_v,
                             input logic [20:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t mismatch %s: expected 0x%0h, actual 0x%0h", $time, label, exp_v, act_v);
      mismatches++;
    end
  endtask

  // Receiver and checker.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      hold_left = 0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.read_data   = m_axis_tdata_o[7:0];
        got.bg_rom_addr = m_axis_tdata_o[28:8];
        got.fg_rom_addr = m_axis_tdata_o[49:29];
        got.pixel_color = m_axis_tdata_o[64:50];
        if (expected_results.size() == 0) begin
          $display("%0t unexpected result: expected none, actual 0x%0h", $time,
                   m_axis_tdata_o);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("read_data", 21'(want.read_data), 21'(got.read_data));
          check_field("bg_rom_addr", want.bg_rom_addr, got.bg_rom_addr);
          check_field("fg_rom_addr", want.fg_rom_addr, got.fg_rom_addr);
          check_field("pixel_color", 21'(want.pixel_color), 21'(got.pixel_color));
          check_field("padding", 21'd0, 21'(m_axis_tdata_o[71:65]));
        end
        results_seen++;
        // Back-pressure long enough for the block to stall its input.
        if (results_seen == 300) begin
          hold_left = HOLD_CYCLES;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= quiet || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= WATCHDOG_MAX) begin
          $display("[FAIL] regression broken");
          $finish;
        end
      end
    end
  end

  initial begin
    mismatches   = 0;
    results_seen = 0;
    stall_cycles = 0;
    cycle_count  = 0;
    build_stimulus();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (pending_reqs.size() != 0 || s_axis_tvalid_i || expected_results.size() != 0);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
